### hw/rtl/cfrc_pkg.sv
// Shared types and constants for the command frame receiver.
// Used by cfrc_front, cfrc_queue, cfrc_back and command_frame_receiver_core.
`timescale 1ns / 1ps
`default_nettype none

package cfrc_pkg;

   // Input beat kinds.
   localparam logic [1:0] MODE_BYTE   = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_TABLE  = 2'd2;
   localparam logic [1:0] MODE_DETACH = 2'd3;

   // Jobs handed from the front to the back.
   localparam logic [1:0] JOB_STORE = 2'd0;
   localparam logic [1:0] JOB_ACK   = 2'd1;
   localparam logic [1:0] JOB_NAK   = 2'd2;

   localparam logic [7:0]  ACK_CODE      = 8'hA0;
   localparam logic [7:0]  NAK_CODE      = 8'hA1;
   localparam logic [7:0]  NAK_FILL      = 8'h00;
   localparam logic [5:0]  CHECK_BYTES   = 6'd2;
   localparam logic [31:0] TIMEOUT_RESET = 32'd200000000;

   localparam int LEN_W       = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data;   // payload byte, or header for a frame end
      logic [LEN_W-1:0] idx;    // store index, or payload count for a frame end
   } job_type;

endpackage

`default_nettype wire

### hw/rtl/command_frame_receiver_core.sv
// Command frame receiver. Every request beat passes the front end as a table read, then an
// update; the front takes no new beat until the update is done. With the queue and back end
// idle, the frame-end beat passes the front's beat register, a queue slot, the back end's
// state and output registers before the first reply beat is valid. Replies then leave at
// one per cycle while rsp_ready is high; payload beats are paced by the store's registered read.
// Reset is synchronous: it clears all command table entries to invalid, the frame state and
// the queue, and loads the timeout with 200000000 ticks; the payload store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver_core
   import cfrc_pkg::*;
#(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_mode,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_entry_valid,
   input  wire logic [LEN_W-1:0] req_entry_length,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_channel,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_timeout_ticks
);

   // Longest payload a table entry may declare; longer writes are clamped to it.
   localparam int PAYLOAD_MAX = ((FRAME_BYTES - 3) < 29) ? (FRAME_BYTES - 3) : 29;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type pop_job;

   // The timeout register can always take a write beat.
   assign csr_ready = 1'b1;

   // Front end: classifies each beat, tracks the running frame and its checksum, and
   // queues one store job per payload byte plus an ack or nak job at frame end.
   cfrc_front #(
      .PAYLOAD_MAX(PAYLOAD_MAX)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_data_byte    (req_data_byte),
      .req_entry_valid  (req_entry_valid),
      .req_entry_length (req_entry_length),
      .csr_valid        (csr_valid),
      .csr_timeout_ticks(csr_timeout_ticks),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   // Jobs run in order, so payload writes of a new frame never overtake the emission of
   // the previous frame's payload.
   cfrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // Back end: stores payload bytes and plays out replies and accepted commands through
   // its output register.
   cfrc_back #(
      .STORE_DEPTH(PAYLOAD_MAX)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_channel (rsp_channel),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job queue popped while empty");

   a_front_pacing: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("front end took a beat while still processing the previous one");
`endif

endmodule

`default_nettype wire

### hw/rtl/cfrc_front.sv
// Front end: accepts beats, keeps the command table, frame tracking, checksum and timeout.
// Depends on cfrc_pkg; pushes store and frame-end jobs into cfrc_queue.
`timescale 1ns / 1ps
`default_nettype none

module cfrc_front
   import cfrc_pkg::*;
#(
   parameter int PAYLOAD_MAX = 29
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_mode,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_entry_valid,
   input  wire logic [LEN_W-1:0]  req_entry_length,
   input  wire logic              csr_valid,
   input  wire logic [31:0]       csr_timeout_ticks,
   input  wire logic              q_full,
   output logic                   q_push,
   output job_type                q_job
);

   localparam logic F_ACCEPT = 1'b0;
   localparam logic F_PROC   = 1'b1;

   logic             state_ff, state_in;
   logic [1:0]       mode_ff;
   logic [7:0]       byte_ff;
   logic [255:0]     valid_ff;
   logic [LEN_W-1:0] len_mem [0:255];
   logic [LEN_W-1:0] len_rd_ff;
   logic             vld_rd_ff;
   logic [5:0]       expected_ff, expected_in;
   logic [7:0]       header_ff, header_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       hi_ff, hi_in;
   logic [31:0]      idle_ff, idle_in;
   logic [31:0]      timeout_ff;
   logic             accept;
   logic [LEN_W-1:0] len_sat;
   logic [31:0]      idle_inc;

   assign req_ready = (state_ff == F_ACCEPT) && !q_full;
   assign accept    = req_valid && req_ready;
   assign len_sat   = (req_entry_length > LEN_W'(PAYLOAD_MAX)) ?
                      LEN_W'(PAYLOAD_MAX) : req_entry_length;
   assign idle_inc  = (idle_ff == '1) ? idle_ff : idle_ff + 32'd1;

   // Table lengths: one write port, registered read at the accept edge.
   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_TABLE) begin
         len_mem[req_data_byte] <= len_sat;
      end
      if (accept) begin
         len_rd_ff <= len_mem[req_data_byte];
         vld_rd_ff <= valid_ff[req_data_byte];
         mode_ff   <= req_mode;
         byte_ff   <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (accept && req_mode == MODE_TABLE) begin
         valid_ff[req_data_byte] <= req_entry_valid;
      end
   end

   always_comb begin
      state_in    = state_ff;
      expected_in = expected_ff;
      header_in   = header_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      hi_in       = hi_ff;
      idle_in     = idle_ff;
      q_push      = 1'b0;
      q_job.kind  = JOB_STORE;
      q_job.data  = byte_ff;
      q_job.idx   = fill_ff;
      case (state_ff)
         F_ACCEPT: begin
            if (accept) begin
               state_in = F_PROC;
            end
         end
         F_PROC: begin
            state_in = F_ACCEPT;
            case (mode_ff)
               MODE_BYTE: begin
                  idle_in = '0;
                  if (expected_ff == 6'd0) begin
                     if (vld_rd_ff) begin
                        header_in   = byte_ff;
                        sum_in      = {8'd0, byte_ff};
                        fill_in     = '0;
                        expected_in = {1'b0, len_rd_ff} + CHECK_BYTES;
                     end
                  end else if (expected_ff > CHECK_BYTES) begin
                     q_push      = 1'b1;
                     fill_in     = fill_ff + LEN_W'(1);
                     sum_in      = sum_ff + {8'd0, byte_ff};
                     expected_in = expected_ff - 6'd1;
                  end else if (expected_ff == CHECK_BYTES) begin
                     hi_in       = byte_ff;
                     expected_in = expected_ff - 6'd1;
                  end else begin
                     q_push      = 1'b1;
                     q_job.kind  = (sum_ff == {hi_ff, byte_ff}) ? JOB_ACK : JOB_NAK;
                     q_job.data  = header_ff;
                     expected_in = '0;
                     fill_in     = '0;
                     idle_in     = '0;
                  end
               end
               MODE_TICK: begin
                  if (expected_ff != 6'd0) begin
                     idle_in = idle_inc;
                     if (idle_inc > timeout_ff) begin
                        expected_in = '0;
                        fill_in     = '0;
                        idle_in     = '0;
                     end
                  end else begin
                     idle_in = '0;
                  end
               end
               MODE_DETACH: begin
                  expected_in = '0;
                  fill_in     = '0;
                  idle_in     = '0;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = F_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_ACCEPT;
         expected_ff <= '0;
         header_ff   <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         hi_ff       <= '0;
         idle_ff     <= '0;
         timeout_ff  <= TIMEOUT_RESET;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         header_ff   <= header_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         hi_ff       <= hi_in;
         idle_ff     <= idle_in;
         if (csr_valid) begin
            timeout_ff <= csr_timeout_ticks;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cfrc_queue.sv
// Short job queue between the front and the back of the receiver.
// Depends on cfrc_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cfrc_queue
   import cfrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   job_type             slot_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (QUEUE_AW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (QUEUE_AW+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cfrc_back.sv
// Back end: holds the payload store and emits reply and command beats from queued jobs.
// Depends on cfrc_pkg; pops jobs from cfrc_queue and drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module cfrc_back
   import cfrc_pkg::*;
#(
   parameter int STORE_DEPTH = 29
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_empty,
   input  wire job_type q_job,
   output logic       q_pop,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output logic       rsp_channel,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_REPLY = 3'd1;
   localparam logic [2:0] B_HDR   = 3'd2;
   localparam logic [2:0] B_RD    = 3'd3;
   localparam logic [2:0] B_PAY   = 3'd4;

   logic [7:0]       store_mem [0:STORE_DEPTH-1];
   logic [7:0]       rd_ff;
   logic [2:0]       state_ff, state_in;
   logic             ack_ff, ack_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       step_ff, step_in;
   logic [LEN_W-1:0] pidx_ff, pidx_in;
   logic             valid_ff, valid_in;
   logic             channel_ff, channel_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic [8:0]       reply_sum;
   logic [7:0]       reply_byte;
   logic             reply_last;
   logic             pay_last;

   assign out_free     = !valid_ff || rsp_ready;
   assign reply_sum    = {1'b0, hdr_ff} + {1'b0, ACK_CODE};
   assign pay_last     = (pidx_ff + LEN_W'(1)) == cnt_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_channel  = channel_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

   always_comb begin
      reply_last = 1'b0;
      if (ack_ff) begin
         reply_last = (step_ff == 2'd3);
         case (step_ff)
            2'd0:    reply_byte = ACK_CODE;
            2'd1:    reply_byte = hdr_ff;
            2'd2:    reply_byte = {7'd0, reply_sum[8]};
            default: reply_byte = reply_sum[7:0];
         endcase
      end else begin
         reply_last = (step_ff == 2'd2);
         case (step_ff)
            2'd1:    reply_byte = NAK_FILL;
            default: reply_byte = NAK_CODE;
         endcase
      end
   end

   // Payload store: written by store jobs, read one entry per cycle.
   always_ff @(posedge clock) begin
      if (q_pop && q_job.kind == JOB_STORE) begin
         store_mem[q_job.idx[STORE_AW-1:0]] <= q_job.data;
      end
      rd_ff <= store_mem[pidx_ff[STORE_AW-1:0]];
   end

   always_comb begin
      state_in   = state_ff;
      ack_in     = ack_ff;
      hdr_in     = hdr_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      pidx_in    = pidx_ff;
      q_pop      = 1'b0;
      valid_in   = valid_ff && !rsp_ready;
      channel_in = channel_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               hdr_in  = q_job.data;
               cnt_in  = q_job.idx;
               step_in = '0;
               case (q_job.kind)
                  JOB_ACK: begin
                     ack_in   = 1'b1;
                     state_in = B_REPLY;
                  end
                  JOB_NAK: begin
                     ack_in   = 1'b0;
                     state_in = B_REPLY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_REPLY: begin
            if (out_free) begin
               valid_in   = 1'b1;
               channel_in = 1'b0;
               byte_in    = reply_byte;
               last_in    = reply_last;
               if (reply_last) begin
                  state_in = ack_ff ? B_HDR : B_IDLE;
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         B_HDR: begin
            if (out_free) begin
               valid_in   = 1'b1;
               channel_in = 1'b1;
               byte_in    = hdr_ff;
               last_in    = (cnt_ff == '0);
               pidx_in    = '0;
               state_in   = (cnt_ff == '0) ? B_IDLE : B_RD;
            end
         end
         B_RD: begin
            state_in = B_PAY;
         end
         B_PAY: begin
            if (out_free) begin
               valid_in   = 1'b1;
               channel_in = 1'b1;
               byte_in    = rd_ff;
               last_in    = pay_last;
               if (pay_last) begin
                  state_in = B_IDLE;
               end else begin
                  pidx_in  = pidx_ff + LEN_W'(1);
                  state_in = B_RD;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      channel_ff <= channel_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
      hdr_ff     <= hdr_in;
      cnt_ff     <= cnt_in;
      ack_ff     <= ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         step_ff  <= '0;
         pidx_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pidx_ff  <= pidx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire
